// ===== rtl/urin_pkg.sv =====
// urin_pkg: shared constants of the URI path normalizer.
// Buffer sizes, derived widths, character codes and status codes.
// No dependencies.
package urin_pkg;

    // Buffer size and result limit
    localparam int MAX_URI      = 64;
    localparam int RESULT_LIMIT = 64;

    // Derived widths
    localparam int CHAR_W   = 8;
    localparam int STAT_W   = 2;
    localparam int UADDR_W  = $clog2(MAX_URI);       // uri buffer address
    localparam int LEN_W    = $clog2(MAX_URI + 1);   // uri length / position
    localparam int WADDR_W  = $clog2(MAX_URI + 2);   // work buffer address
    localparam int WLEN_W   = $clog2(MAX_URI + 3);   // work buffer fill

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_PCT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;  // '?'
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;  // 'F'

endpackage

// ===== rtl/uri_path_normalizer_core.sv =====
// uri_path_normalizer_core: extracts and normalizes the path of a request URI.
// Uses urin_pkg for sizes and codes; holds the uri and work buffers.
//
// URI bytes are taken one word per cycle into a 64-byte buffer; s_tready is
// high only while loading. After the word with s_tlast the block walks the
// buffer with one shared decode/segment unit: scheme and host skip, copy,
// percent decode and dot-segment collapse run as one pass over the URI
// bytes, and a ".." segment backs up over the output one character at a
// time. Each character of the normalized path is then sent by a memory
// read, an output register and a handshake. An error ends the work at once
// and sends a single word with m_tlast set and a nonzero status.
module uri_path_normalizer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [urin_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] uri_char
    input  logic                          s_tlast,   // uri_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [urin_pkg::CHAR_W-1:0]   m_tdata,   // [7:0] path_char
    output logic                          m_tlast,   // run_end
    output logic [urin_pkg::STAT_W-1:0]   m_tuser    // [1:0] status
);
    import urin_pkg::*;

    typedef enum logic [15:0] {
        ST_LOAD   = 16'b0000_0000_0000_0001,
        ST_HOST_A = 16'b0000_0000_0000_0010,
        ST_HOST_B = 16'b0000_0000_0000_0100,
        ST_HOST_C = 16'b0000_0000_0000_1000,
        ST_HOST_D = 16'b0000_0000_0001_0000,
        ST_SKIP_A = 16'b0000_0000_0010_0000,
        ST_SKIP_B = 16'b0000_0000_0100_0000,
        ST_COPY_A = 16'b0000_0000_1000_0000,
        ST_COPY_B = 16'b0000_0001_0000_0000,
        ST_POP0   = 16'b0000_0010_0000_0000,
        ST_POP_A  = 16'b0000_0100_0000_0000,
        ST_POP_B  = 16'b0000_1000_0000_0000,
        ST_FIN    = 16'b0001_0000_0000_0000,
        ST_EMIT_A = 16'b0010_0000_0000_0000,
        ST_EMIT_B = 16'b0100_0000_0000_0000,
        ST_OUT    = 16'b1000_0000_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        DEC_NORM = 3'b001,
        DEC_HI   = 3'b010,
        DEC_LO   = 3'b100
    } dec_t;

    // hex digit check: {valid, value}
    function automatic logic [4:0] hex_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        hex_val = '0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            hex_val = {1'b1, d[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA + 8'd10;
            hex_val = {1'b1, d[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
            hex_val = {1'b1, d[3:0]};
        end
    endfunction

    // Buffers
    logic [CHAR_W-1:0] uri_mem  [MAX_URI];
    logic [CHAR_W-1:0] work_mem [MAX_URI+2];

    // Control registers
    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic              nul_reg, nul_next;
    logic              sch_reg, sch_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [LEN_W-1:0]  p_reg, p_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    dec_t              dec_reg, dec_next;
    logic [3:0]        hi_reg, hi_next;
    logic              cut_reg, cut_next;
    logic [1:0]        seg_len_reg, seg_len_next;
    logic              dot_reg, dot_next;
    logic [WLEN_W-1:0] seg_start_reg, seg_start_next;
    logic [WLEN_W-1:0] w_reg, w_next;
    logic [WLEN_W-1:0] k_reg, k_next;
    logic              last_reg, last_next;
    logic              m_valid_reg, m_valid_next;

    // Payload registers
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [CHAR_W-1:0] uri_rd_reg;
    logic [CHAR_W-1:0] work_rd_reg;

    // Memory ports
    logic               uri_wen;
    logic [UADDR_W-1:0] uri_raddr;
    logic               work_wen;
    logic [WADDR_W-1:0] work_waddr;
    logic [CHAR_W-1:0]  work_wdata;
    logic [WADDR_W-1:0] work_raddr;
    logic [WLEN_W-1:0]  w_dec;

    // Shared decode / segment unit
    logic              feed_en;
    logic [CHAR_W-1:0] feed_c;
    logic              feed_last;
    dec_t              f_dec_next;
    logic [3:0]        f_hi_next;
    logic              f_cut_next;
    logic [1:0]        f_seg_len_next;
    logic              f_dot_next;
    logic [WLEN_W-1:0] f_seg_start_next;
    logic [WLEN_W-1:0] f_w_next;
    logic              f_err;
    logic              f_pop;
    logic              f_wen;
    logic [CHAR_W-1:0] f_wdata;
    logic              dec_ok;
    logic [CHAR_W-1:0] dec_c;
    logic [CHAR_W-1:0] clp_c;
    logic [4:0]        hv;

    logic              s_acc;
    logic              is_delim;
    logic              uri_stop;
    logic [WLEN_W-1:0] wf;

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_char_reg;
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_status_reg;

    assign is_delim  = (s_tdata == CH_COLON) || (s_tdata == CH_SLASH) ||
                       (s_tdata == CH_QUEST) || (s_tdata == CH_HASH);
    assign uri_stop  = (uri_rd_reg == CH_QUEST) || (uri_rd_reg == CH_HASH);
    assign uri_raddr = pos_reg[UADDR_W-1:0];
    assign w_dec     = w_reg - 1'b1;
    assign work_raddr = (state_reg == ST_POP_A || state_reg == ST_POP_B) ?
                        w_dec[WADDR_W-1:0] : k_reg[WADDR_W-1:0];
    assign wf        = (w_reg > WLEN_W'(1)) ? w_dec : w_reg;

    // Percent decoder feeding the segment collapser
    always_comb begin
        f_dec_next       = dec_reg;
        f_hi_next        = hi_reg;
        f_cut_next       = cut_reg;
        f_seg_len_next   = seg_len_reg;
        f_dot_next       = dot_reg;
        f_seg_start_next = seg_start_reg;
        f_w_next         = w_reg;
        f_err            = 1'b0;
        f_pop            = 1'b0;
        f_wen            = 1'b0;
        f_wdata          = feed_c;
        dec_ok           = 1'b0;
        dec_c            = feed_c;
        hv               = hex_val(feed_c);

        unique case (dec_reg)
            DEC_NORM: begin
                if (feed_c == CH_PCT) f_dec_next = DEC_HI;
                else                  dec_ok     = 1'b1;
            end
            DEC_HI: begin
                if (hv[4]) begin
                    f_hi_next  = hv[3:0];
                    f_dec_next = DEC_LO;
                end else begin
                    f_err = 1'b1;
                end
            end
            DEC_LO: begin
                if (hv[4]) begin
                    dec_c      = {hi_reg, hv[3:0]};
                    dec_ok     = 1'b1;
                    f_dec_next = DEC_NORM;
                end else begin
                    f_err = 1'b1;
                end
            end
            default: f_err = 1'b1;
        endcase

        // decoded NUL ends the path with a closing slash
        clp_c = (dec_c == CH_NUL) ? CH_SLASH : dec_c;

        if (dec_ok && !cut_reg) begin
            if (dec_c == CH_NUL) f_cut_next = 1'b1;
            if (clp_c != CH_SLASH) begin
                f_wen    = 1'b1;
                f_wdata  = clp_c;
                f_w_next = w_reg + 1'b1;
                if (seg_len_reg == 2'd0) f_seg_start_next = w_reg;
                if (seg_len_reg != 2'd3) f_seg_len_next = seg_len_reg + 1'b1;
                f_dot_next = dot_reg && (clp_c == CH_DOT);
            end else begin
                f_seg_len_next = 2'd0;
                f_dot_next     = 1'b1;
                // segment end: drop ".", back up on "..", else keep
                if (seg_len_reg != 2'd0) begin
                    if (dot_reg && seg_len_reg == 2'd1) begin
                        f_w_next = seg_start_reg;
                    end else if (dot_reg && seg_len_reg == 2'd2) begin
                        f_w_next = seg_start_reg;
                        f_pop    = 1'b1;
                    end else begin
                        f_wen    = 1'b1;
                        f_wdata  = CH_SLASH;
                        f_w_next = w_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        nul_next        = nul_reg;
        sch_next        = sch_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        pos_next        = pos_reg;
        dec_next        = dec_reg;
        hi_next         = hi_reg;
        cut_next        = cut_reg;
        seg_len_next    = seg_len_reg;
        dot_next        = dot_reg;
        seg_start_next  = seg_start_reg;
        w_next          = w_reg;
        k_next          = k_reg;
        last_next       = last_reg;
        m_valid_next    = m_valid_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        uri_wen         = 1'b0;
        work_wen        = 1'b0;
        work_waddr      = w_reg[WADDR_W-1:0];
        work_wdata      = f_wdata;
        feed_en         = 1'b0;
        feed_c          = uri_rd_reg;
        feed_last       = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (len_reg < LEN_W'(MAX_URI)) begin
                        uri_wen  = 1'b1;
                        len_next = len_reg + 1'b1;
                        // track NUL end and scheme delimiter while loading
                        if (!nul_reg) begin
                            if (s_tdata == CH_NUL) begin
                                nul_next = 1'b1;
                            end else begin
                                n_next = n_reg + 1'b1;
                                if (!sch_reg && is_delim) begin
                                    sch_next = 1'b1;
                                    p_next   = (s_tdata == CH_COLON) ?
                                               len_reg + 1'b1 : '0;
                                end
                            end
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        if (ovf_next) begin
                            out_char_next   = CH_NUL;
                            out_last_next   = 1'b1;
                            out_status_next = STAT_TOO_LONG;
                            m_valid_next    = 1'b1;
                            state_next      = ST_OUT;
                        end else begin
                            pos_next       = p_next;
                            work_wen       = 1'b1;
                            work_waddr     = '0;
                            work_wdata     = CH_SLASH;
                            w_next         = WLEN_W'(1);
                            dec_next       = DEC_NORM;
                            cut_next       = 1'b0;
                            seg_len_next   = 2'd0;
                            dot_next       = 1'b1;
                            seg_start_next = WLEN_W'(1);
                            last_next      = 1'b0;
                            state_next     = ST_HOST_A;
                        end
                    end
                end
            end
            ST_HOST_A: begin
                if (pos_reg + 1'b1 >= n_reg) state_next = ST_COPY_A;
                else                         state_next = ST_HOST_B;
            end
            ST_HOST_B: begin
                if (uri_rd_reg == CH_SLASH) begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_HOST_C;
                end else begin
                    state_next = ST_COPY_A;
                end
            end
            ST_HOST_C: state_next = ST_HOST_D;
            ST_HOST_D: begin
                if (uri_rd_reg == CH_SLASH) begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_SKIP_A;
                end else begin
                    pos_next   = pos_reg - 1'b1;
                    state_next = ST_COPY_A;
                end
            end
            ST_SKIP_A: begin
                if (pos_reg >= n_reg) state_next = ST_COPY_A;
                else                  state_next = ST_SKIP_B;
            end
            ST_SKIP_B: begin
                if (uri_stop || uri_rd_reg == CH_SLASH) begin
                    state_next = ST_COPY_A;
                end else begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_SKIP_A;
                end
            end
            ST_COPY_A: begin
                if (pos_reg >= n_reg) begin
                    feed_en   = 1'b1;
                    feed_c    = CH_SLASH;
                    feed_last = 1'b1;
                end else begin
                    state_next = ST_COPY_B;
                end
            end
            ST_COPY_B: begin
                feed_en = 1'b1;
                if (uri_stop) begin
                    feed_c    = CH_SLASH;
                    feed_last = 1'b1;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_POP0: begin
                if (w_reg > WLEN_W'(1)) begin
                    w_next     = w_dec;
                    state_next = ST_POP_A;
                end else begin
                    state_next = last_reg ? ST_FIN : ST_COPY_A;
                end
            end
            ST_POP_A: begin
                if (w_reg <= WLEN_W'(1)) state_next = last_reg ? ST_FIN : ST_COPY_A;
                else                     state_next = ST_POP_B;
            end
            ST_POP_B: begin
                if (work_rd_reg == CH_SLASH) begin
                    state_next = last_reg ? ST_FIN : ST_COPY_A;
                end else begin
                    w_next     = w_dec;
                    state_next = ST_POP_A;
                end
            end
            ST_FIN: begin
                if (int'(wf) > RESULT_LIMIT) begin
                    out_char_next   = CH_NUL;
                    out_last_next   = 1'b1;
                    out_status_next = STAT_TOO_LONG;
                    m_valid_next    = 1'b1;
                    state_next      = ST_OUT;
                end else begin
                    w_next     = wf;
                    k_next     = '0;
                    state_next = ST_EMIT_A;
                end
            end
            ST_EMIT_A: state_next = ST_EMIT_B;
            ST_EMIT_B: begin
                out_char_next   = work_rd_reg;
                out_last_next   = (k_reg + 1'b1 == w_reg);
                out_status_next = STAT_OK;
                m_valid_next    = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (out_last_reg) begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        nul_next   = 1'b0;
                        sch_next   = 1'b0;
                        n_next     = '0;
                        p_next     = '0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EMIT_A;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase

        // apply one character step of the shared unit
        if (feed_en) begin
            dec_next       = f_dec_next;
            hi_next        = f_hi_next;
            cut_next       = f_cut_next;
            seg_len_next   = f_seg_len_next;
            dot_next       = f_dot_next;
            seg_start_next = f_seg_start_next;
            w_next         = f_w_next;
            work_wen       = f_wen;
            work_waddr     = w_reg[WADDR_W-1:0];
            work_wdata     = f_wdata;
            priority if (f_err) begin
                work_wen        = 1'b0;
                out_char_next   = CH_NUL;
                out_last_next   = 1'b1;
                out_status_next = STAT_BAD_PCT;
                m_valid_next    = 1'b1;
                state_next      = ST_OUT;
            end else if (f_pop) begin
                last_next  = feed_last;
                state_next = ST_POP0;
            end else if (feed_last) begin
                state_next = ST_FIN;
            end else begin
                state_next = ST_COPY_A;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            nul_reg     <= 1'b0;
            sch_reg     <= 1'b0;
            n_reg       <= '0;
            p_reg       <= '0;
            m_valid_reg <= 1'b0;
            dec_reg     <= DEC_NORM;
            cut_reg     <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            nul_reg     <= nul_next;
            sch_reg     <= sch_next;
            n_reg       <= n_next;
            p_reg       <= p_next;
            m_valid_reg <= m_valid_next;
            dec_reg     <= dec_next;
            cut_reg     <= cut_next;
            last_reg    <= last_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        hi_reg         <= hi_next;
        seg_len_reg    <= seg_len_next;
        dot_reg        <= dot_next;
        seg_start_reg  <= seg_start_next;
        w_reg          <= w_next;
        k_reg          <= k_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    // URI buffer
    always_ff @(posedge aclk) begin
        if (uri_wen) uri_mem[len_reg[UADDR_W-1:0]] <= s_tdata;
        uri_rd_reg <= uri_mem[uri_raddr];
    end

    // Work buffer
    always_ff @(posedge aclk) begin
        if (work_wen) work_mem[work_waddr] <= work_wdata;
        work_rd_reg <= work_mem[work_raddr];
    end

endmodule

// ===== rtl/urin_check.sv =====
// urin_check: port-level assertions for uri_path_normalizer_core.
// Uses urin_pkg status codes; bound to the top level below.
module urin_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [urin_pkg::CHAR_W-1:0]   m_tdata,
    input logic                          m_tlast,
    input logic [urin_pkg::STAT_W-1:0]   m_tuser
);
    import urin_pkg::*;

    // never loading while a result word is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // an error word is a lone, last word with a zero character
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tlast && m_tdata == CH_NUL))
        else $error("malformed error word");

    // last word of a run returns the block to loading
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("not loading after end of run");

    // the final URI byte starts processing
    a_busy_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("still loading after final byte");

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output word changed while stalled");

endmodule

bind uri_path_normalizer_core urin_check u_urin_check (.*);
